// ===== sv/uer_pkg.sv =====
// Shared types, register map and status codes for the ultrasonic echo ranger.
package uer_pkg;

   localparam int DIST_BITS   = 18;
   localparam int STATUS_BITS = 3;
   localparam int INDEX_BITS  = 3;

   localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

   localparam logic [INDEX_BITS-1:0] REG_ENABLED  = 3'd0;
   localparam logic [INDEX_BITS-1:0] REG_TRIGGER  = 3'd1;
   localparam logic [INDEX_BITS-1:0] REG_TIMEOUT  = 3'd2;
   localparam logic [INDEX_BITS-1:0] REG_HOLDOFF  = 3'd3;
   localparam logic [INDEX_BITS-1:0] REG_SPEED    = 3'd4;
   localparam logic [INDEX_BITS-1:0] REG_MIN_DIST = 3'd5;
   localparam logic [INDEX_BITS-1:0] REG_MAX_DIST = 3'd6;

   localparam logic [STATUS_BITS-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_NOECHO   = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_LONG     = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_RANGE    = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_DISABLED = 3'd4;

   typedef struct packed {
      logic                 enabled;
      logic [7:0]           trigger_ticks;
      logic [15:0]          timeout_ticks;
      logic [15:0]          holdoff_ticks;
      logic [15:0]          speed_factor;
      logic [DIST_BITS-1:0] min_distance;
      logic [DIST_BITS-1:0] max_distance;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      enabled:       1'b0,
      trigger_ticks: 8'd10,
      timeout_ticks: 16'd30000,
      holdoff_ticks: 16'd1000,
      speed_factor:  16'd1124,
      min_distance:  18'd512,
      max_distance:  18'd102400
   };

   typedef struct packed {
      logic                   trigger_level;
      logic                   busy_res;
      logic                   result_valid;
      logic [STATUS_BITS-1:0] status;
      logic [DIST_BITS-1:0]   distance;
   } rsp_type;

endpackage

// ===== sv/uer_csr.sv =====
// APB-style configuration register file for the ultrasonic echo ranger.
module uer_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [4:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output uer_pkg::cfg_type cfg
);
   import uer_pkg::*;

   cfg_type                 cfg_ff;
   logic                    wr_en;
   logic [INDEX_BITS-1:0]   index;

   assign csr_pready = 1'b1;
   assign index      = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (wr_en) begin
         unique case (index)
            REG_ENABLED:  cfg_ff.enabled       <= csr_pwdata[0];
            REG_TRIGGER:  cfg_ff.trigger_ticks <= csr_pwdata[7:0];
            REG_TIMEOUT:  cfg_ff.timeout_ticks <= csr_pwdata[15:0];
            REG_HOLDOFF:  cfg_ff.holdoff_ticks <= csr_pwdata[15:0];
            REG_SPEED:    cfg_ff.speed_factor  <= csr_pwdata[15:0];
            REG_MIN_DIST: cfg_ff.min_distance  <= csr_pwdata[DIST_BITS-1:0];
            REG_MAX_DIST: cfg_ff.max_distance  <= csr_pwdata[DIST_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_ENABLED:  csr_prdata = {31'b0, cfg_ff.enabled};
         REG_TRIGGER:  csr_prdata = {24'b0, cfg_ff.trigger_ticks};
         REG_TIMEOUT:  csr_prdata = {16'b0, cfg_ff.timeout_ticks};
         REG_HOLDOFF:  csr_prdata = {16'b0, cfg_ff.holdoff_ticks};
         REG_SPEED:    csr_prdata = {16'b0, cfg_ff.speed_factor};
         REG_MIN_DIST: csr_prdata = {{(32-DIST_BITS){1'b0}}, cfg_ff.min_distance};
         REG_MAX_DIST: csr_prdata = {{(32-DIST_BITS){1'b0}}, cfg_ff.max_distance};
         default:      csr_prdata = 32'b0;
      endcase
   end

endmodule

// ===== sv/uer_step.sv =====
// Measurement sequencer: phase and tick counters, distance conversion and range check.
module uer_step #(
   parameter int COUNT_BITS = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             start_req,
   input  logic             echo_level,
   input  uer_pkg::cfg_type cfg,
   output uer_pkg::rsp_type rsp,
   output logic             trig_phase,
   output logic             trig_count_nonzero
);
   import uer_pkg::*;

   localparam int WIDE = COUNT_BITS + 16;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_TRIG = 3'd1;
   localparam logic [2:0] PH_RISE = 3'd2;
   localparam logic [2:0] PH_HIGH = 3'd3;
   localparam logic [2:0] PH_HOLD = 3'd4;

   logic [2:0]            phase_ff, phase_in;
   logic [COUNT_BITS-1:0] tick_ff, tick_in;
   logic [COUNT_BITS-1:0] echo_ff, echo_in;
   logic [COUNT_BITS-1:0] tick_inc, echo_base, echo_inc;
   logic                  tick_over, echo_over;
   logic [WIDE-1:0]       product, scaled;
   logic [DIST_BITS-1:0]  dist_sat;

   assign tick_inc  = (tick_ff < CNT_MAX) ? tick_ff + 1'b1 : tick_ff;
   assign echo_base = (phase_ff == PH_RISE) ? '0 : echo_ff;
   assign echo_inc  = (echo_base < CNT_MAX) ? echo_base + 1'b1 : echo_base;
   assign tick_over = (WIDE'(tick_inc) > WIDE'(cfg.timeout_ticks)) || (tick_inc == CNT_MAX);
   assign echo_over = (WIDE'(echo_inc) > WIDE'(cfg.timeout_ticks)) || (echo_inc == CNT_MAX);

   assign product  = WIDE'(echo_ff) * WIDE'(cfg.speed_factor);
   assign scaled   = product >> 8;
   assign dist_sat = (scaled > WIDE'(DIST_MAX)) ? DIST_MAX : scaled[DIST_BITS-1:0];

   assign trig_phase         = (phase_ff == PH_TRIG);
   assign trig_count_nonzero = (tick_ff != '0);

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      echo_in  = echo_ff;
      rsp      = '0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (start_req) begin
               if (!cfg.enabled) begin
                  rsp.result_valid = 1'b1;
                  rsp.status       = ST_DISABLED;
               end else begin
                  rsp.trigger_level = 1'b1;
                  if (cfg.trigger_ticks <= 8'd1) begin
                     phase_in = PH_RISE;
                     tick_in  = '0;
                  end else begin
                     phase_in = PH_TRIG;
                     tick_in  = COUNT_BITS'(1);
                  end
               end
            end
         end
         PH_TRIG: begin
            rsp.trigger_level = 1'b1;
            tick_in           = tick_inc;
            if (tick_inc >= COUNT_BITS'(cfg.trigger_ticks)) begin
               phase_in = PH_RISE;
               tick_in  = '0;
            end
         end
         PH_RISE, PH_HIGH: begin
            if (phase_ff == PH_RISE && !echo_level) begin
               tick_in = tick_inc;
               if (tick_over) begin
                  rsp.result_valid = 1'b1;
                  rsp.status       = ST_NOECHO;
                  phase_in         = PH_IDLE;
               end
            end else if (echo_level) begin
               phase_in = PH_HIGH;
               echo_in  = echo_inc;
               if (echo_over) begin
                  tick_in = '0;
                  if (cfg.holdoff_ticks == 16'd0) begin
                     rsp.result_valid = 1'b1;
                     rsp.status       = ST_LONG;
                     phase_in         = PH_IDLE;
                  end else begin
                     phase_in = PH_HOLD;
                  end
               end
            end else begin
               rsp.result_valid = 1'b1;
               phase_in         = PH_IDLE;
               if (dist_sat < cfg.min_distance || dist_sat > cfg.max_distance) begin
                  rsp.status = ST_RANGE;
               end else begin
                  rsp.status   = ST_OK;
                  rsp.distance = dist_sat;
               end
            end
         end
         PH_HOLD: begin
            tick_in = tick_inc;
            if (WIDE'(tick_inc) >= WIDE'(cfg.holdoff_ticks)) begin
               rsp.result_valid = 1'b1;
               rsp.status       = ST_LONG;
               phase_in         = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
      rsp.busy_res = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         echo_ff  <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         echo_ff  <= echo_in;
      end
   end

endmodule

// ===== sv/ultrasonic_echo_ranger.sv =====
// Top level of the ultrasonic echo ranger: input register, sequencer, result register, CSRs.
//
// Each req_ word is one microsecond tick carrying the echo pin sample and a
// start request; each tick yields exactly one rsp_ word with the trigger drive,
// busy flag and, on the tick a measurement ends, its status and distance.
// A word is taken when valid is high and stall is low on its channel.
// An accepted req_ word goes into the input register; its rsp_ word is then
// loaded into the result register. Throughput: one word per cycle while rsp_stall is low,
// set by the sequencer update and the one 16-bit by COUNT_BITS
// multiply feeding the distance check ahead of the result register.
// When rsp_stall is high on a valid result the result register holds; an empty input register
// still takes one more word, then req_stall rises until the result is taken.
// Reset (synchronous, active high) empties both registers, returns the
// sequencer to idle with cleared counters and loads the default register
// values; measurements stay disabled until the enable register is written.
// Write configuration only while no measurement is running.
module ultrasonic_echo_ranger #(
   parameter int COUNT_BITS = 17
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_start_req,
   input  logic        req_echo_level,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_trigger_level,
   output logic        rsp_busy_res,
   output logic        rsp_result_valid,
   output logic [2:0]  rsp_status,
   output logic [17:0] rsp_distance,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import uer_pkg::*;

   cfg_type cfg;
   rsp_type step_rsp;
   rsp_type rsp_ff;
   logic    in_valid_ff, in_start_ff, in_echo_ff;
   logic    rsp_valid_ff;
   logic    out_ready, advance;
   logic    trig_phase, trig_count_nonzero;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;

   uer_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   uer_step #(
      .COUNT_BITS (COUNT_BITS)
   ) u_step (
      .clock              (clock),
      .reset              (reset),
      .advance            (advance),
      .start_req          (in_start_ff),
      .echo_level         (in_echo_ff),
      .cfg                (cfg),
      .rsp                (step_rsp),
      .trig_phase         (trig_phase),
      .trig_count_nonzero (trig_count_nonzero)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (out_ready) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_start_ff <= req_start_req;
         in_echo_ff  <= req_echo_level;
      end
      if (advance) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_trigger_level = rsp_ff.trigger_level;
   assign rsp_busy_res      = rsp_ff.busy_res;
   assign rsp_result_valid  = rsp_ff.result_valid;
   assign rsp_status        = rsp_ff.status;
   assign rsp_distance      = rsp_ff.distance;

   a_status_needs_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != ST_OK |-> rsp_ff.result_valid)
      else $error("status set without a finished measurement");

   a_distance_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.distance != '0 |-> rsp_ff.result_valid && rsp_ff.status == ST_OK)
      else $error("distance reported without an ok result");

   a_refused_start_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == ST_DISABLED |-> !rsp_ff.busy_res && !rsp_ff.trigger_level)
      else $error("refused start left the block busy or triggering");

   a_trigger_count: assert property (@(posedge clock) disable iff (reset)
      trig_phase |-> trig_count_nonzero)
      else $error("trigger phase entered with a zero tick count");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> in_valid_ff)
      else $error("input register lost a word while stalled");

endmodule
